@@ rtl/ros_pkg.sv @@
// ----------------------------------------------------------------------------
// ros_pkg
// Shared codes and the command and status bundles that pass between the
// route override selector's controller and its datapath.
// ----------------------------------------------------------------------------
package ros_pkg;

  // Input modes
  localparam logic [1:0] MODE_REFRESH = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEFAULT_ROUTE   = 2'd0;
  localparam logic [1:0] REG_ROUTE_COUNT     = 2'd1;
  localparam logic [1:0] REG_LAYER_ROUTE_MAP = 2'd2;

  // Result register update selects
  localparam logic [2:0] RES_HOLD    = 3'd0;
  localparam logic [2:0] RES_FLAG    = 3'd1;
  localparam logic [2:0] RES_OVR     = 3'd2;
  localparam logic [2:0] RES_LAYER   = 3'd3;
  localparam logic [2:0] RES_DEFAULT = 3'd4;

  typedef struct packed {
    logic       load;        // capture the item, restart the slot scan
    logic       find_step;   // examine one slot for a match or a free entry
    logic       press_wr;    // claim the chosen slot and stamp it
    logic       release_wr;  // clear the matching slot
    logic       idx_clr;     // restart the slot scan
    logic       pick_step;   // examine one slot for the newest override
    logic       layer_init;  // start the layer scan at the top layer
    logic       layer_step;  // move one layer down
    logic [2:0] res_sel;     // how to update the result registers
    logic [1:0] res_status;  // status for a flag-only result
    logic       out_load;    // move the result into the output register
  } ros_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       scan_last;
    logic       match;
    logic       free;
    logic       target_bad;
    logic       best_found;
    logic       layer_hit;
    logic       layer_end;
  } ros_stat_t;

endpackage

@@ rtl/ros_datapath.sv @@
// ----------------------------------------------------------------------------
// ros_datapath
// Configuration registers, override slot table, scan counters and the
// result and output registers of the route override selector.
// ----------------------------------------------------------------------------
module ros_datapath #(
  parameter int OVERRIDE_SLOTS = 8,
  parameter int NUM_LAYERS     = 16,
  parameter int ROUTE_MAX      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  input  logic [1:0]          mode,
  input  logic [7:0]          key_position,
  input  logic [2:0]          target_route,
  input  logic [15:0]         active_layers,
  input  logic [3:0]          base_layer,
  input  ros_pkg::ros_cmd_t   cmd,
  output ros_pkg::ros_stat_t  stat,
  output logic [1:0]          status,
  output logic                route_valid,
  output logic [2:0]          selected_route,
  output logic                from_override
);
  import ros_pkg::*;

  localparam int SIDX_W = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
  localparam int LIDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  // Configuration
  logic [2:0]  default_route;
  logic [3:0]  route_count;
  logic [63:0] layer_route_map;

  // Captured item
  logic [1:0]  item_mode;
  logic [7:0]  item_pos;
  logic [2:0]  item_target;
  logic [15:0] item_layers;
  logic [3:0]  item_base;

  // Override table
  logic [7:0]  slot_position [OVERRIDE_SLOTS];
  logic [2:0]  slot_route    [OVERRIDE_SLOTS];
  logic [63:0] slot_stamp    [OVERRIDE_SLOTS];
  logic [OVERRIDE_SLOTS-1:0] slot_active;
  logic [63:0] stamp_counter;

  // Scan state
  logic [SIDX_W-1:0] idx;
  logic              match;
  logic [SIDX_W-1:0] match_slot;
  logic              free;
  logic [SIDX_W-1:0] free_slot;
  logic [SIDX_W-1:0] slot_sel;
  logic              best_found;
  logic [63:0]       best_stamp;
  logic [2:0]        best_route;
  logic [LIDX_W-1:0] lidx;
  logic [3:0]        lidx4;
  logic [3:0]        nib;

  // Result
  logic [1:0] res_status;
  logic       res_rvalid;
  logic [2:0] res_route;
  logic       res_ovr;

  logic cur_match;
  logic cur_free;
  logic cur_newer;

  assign slot_sel  = match ? match_slot : free_slot;
  assign lidx4     = 4'(lidx);
  assign nib       = layer_route_map[{lidx4, 2'b00} +: 4];
  assign cur_match = slot_active[idx] && (slot_position[idx] == item_pos);
  assign cur_free  = !slot_active[idx];
  assign cur_newer = slot_active[idx] && (!best_found || (slot_stamp[idx] > best_stamp));

  always_comb begin
    stat.mode       = item_mode;
    stat.scan_last  = (idx == SIDX_W'(OVERRIDE_SLOTS - 1));
    stat.match      = match;
    stat.free       = free;
    stat.target_bad = ({1'b0, item_target} >= route_count) ||
                      ({1'b0, item_target} >= 4'(ROUTE_MAX));
    stat.best_found = best_found;
    stat.layer_hit  = item_layers[lidx4] && nib[3];
    stat.layer_end  = (lidx4 == item_base) || (lidx == '0);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      default_route   <= '0;
      route_count     <= 4'd1;
      layer_route_map <= '0;
      slot_active     <= '0;
      stamp_counter   <= '0;
      idx             <= '0;
      match           <= 1'b0;
      free            <= 1'b0;
      best_found      <= 1'b0;
      lidx            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEFAULT_ROUTE:   default_route   <= cfg_data[2:0];
          REG_ROUTE_COUNT:     route_count     <= cfg_data[3:0];
          REG_LAYER_ROUTE_MAP: layer_route_map <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        idx        <= '0;
        match      <= 1'b0;
        free       <= 1'b0;
        best_found <= 1'b0;
      end
      if (cmd.find_step) begin
        if (cur_match && !match) begin
          match <= 1'b1;
        end
        if (cur_free && !free) begin
          free <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      if (cmd.press_wr) begin
        slot_active[slot_sel] <= 1'b1;
        stamp_counter         <= stamp_counter + 64'd1;
      end
      if (cmd.release_wr) begin
        slot_active[match_slot] <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end
      if (cmd.pick_step) begin
        if (cur_newer) begin
          best_found <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      if (cmd.layer_init) begin
        lidx <= LIDX_W'(NUM_LAYERS - 1);
      end
      if (cmd.layer_step) begin
        lidx <= lidx - 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode   <= mode;
      item_pos    <= key_position;
      item_target <= target_route;
      item_layers <= active_layers;
      item_base   <= base_layer;
    end
    if (cmd.find_step) begin
      if (cur_match && !match) begin
        match_slot <= idx;
      end
      if (cur_free && !free) begin
        free_slot <= idx;
      end
    end
    if (cmd.press_wr) begin
      slot_position[slot_sel] <= item_pos;
      slot_route[slot_sel]    <= item_target;
      slot_stamp[slot_sel]    <= stamp_counter + 64'd1;
    end
    if (cmd.pick_step && cur_newer) begin
      best_stamp <= slot_stamp[idx];
      best_route <= slot_route[idx];
    end
    case (cmd.res_sel)
      RES_FLAG: begin
        res_status <= cmd.res_status;
        res_rvalid <= 1'b0;
        res_route  <= '0;
        res_ovr    <= 1'b0;
      end
      RES_OVR: begin
        res_status <= ST_OK;
        res_rvalid <= 1'b1;
        res_route  <= best_route;
        res_ovr    <= 1'b1;
      end
      RES_LAYER: begin
        res_status <= ST_OK;
        res_rvalid <= 1'b1;
        res_route  <= nib[2:0];
        res_ovr    <= 1'b0;
      end
      RES_DEFAULT: begin
        res_status <= ST_OK;
        res_rvalid <= 1'b1;
        res_route  <= default_route;
        res_ovr    <= 1'b0;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      status         <= res_status;
      route_valid    <= res_rvalid;
      selected_route <= res_route;
      from_override  <= res_ovr;
    end
  end

  // A press always leaves its slot active
  a_press_sets_active: assert property (@(posedge clk) disable iff (rst)
    cmd.press_wr |=> slot_active[$past(slot_sel)])
    else $error("pressed slot not active");

  // The order stamp only advances on a press
  a_stamp_only_on_press: assert property (@(posedge clk) disable iff (rst)
    !cmd.press_wr |=> $stable(stamp_counter))
    else $error("stamp counter moved without a press");

  // A result without a route carries zero route fields
  a_no_route_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_sel == RES_FLAG) |=> (res_route == 3'd0) && !res_ovr && !res_rvalid)
    else $error("flag result carries route fields");

  // A failed press never reports a route
  a_error_no_route: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.out_load) && (status != ST_OK) |-> !route_valid)
    else $error("error status with a valid route");

endmodule

@@ rtl/ros_ctrl.sv @@
// ----------------------------------------------------------------------------
// ros_ctrl
// Sequencer for the route override selector: slot search, table update,
// newest-override scan, layer scan and hand-off to the output register.
// ----------------------------------------------------------------------------
module ros_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  output logic               out_valid,
  input  logic               out_stall,
  input  ros_pkg::ros_stat_t stat,
  output ros_pkg::ros_cmd_t  cmd
);
  import ros_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_PICK   = 3'd3;
  localparam logic [2:0] S_CHOOSE = 3'd4;
  localparam logic [2:0] S_LAYER  = 3'd5;
  localparam logic [2:0] S_POST   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.res_sel    = RES_HOLD;
    cmd.res_status = ST_OK;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (mode == MODE_REFRESH) begin
            state_next = S_PICK;
          end else if (mode == MODE_PRESS || mode == MODE_RELEASE) begin
            state_next = S_FIND;
          end else begin
            cmd.res_sel = RES_FLAG;
            state_next  = S_POST;
          end
        end
      end
      S_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.idx_clr = 1'b1;
        if (stat.mode == MODE_PRESS) begin
          if (stat.target_bad) begin
            cmd.res_sel    = RES_FLAG;
            cmd.res_status = ST_NOT_FOUND;
            state_next     = S_POST;
          end else if (!stat.match && !stat.free) begin
            cmd.res_sel    = RES_FLAG;
            cmd.res_status = ST_NO_SPACE;
            state_next     = S_POST;
          end else begin
            cmd.press_wr = 1'b1;
            state_next   = S_PICK;
          end
        end else if (stat.match) begin
          cmd.release_wr = 1'b1;
          state_next     = S_PICK;
        end else begin
          cmd.res_sel = RES_FLAG;
          state_next  = S_POST;
        end
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        if (stat.best_found) begin
          cmd.res_sel = RES_OVR;
          state_next  = S_POST;
        end else begin
          cmd.layer_init = 1'b1;
          state_next     = S_LAYER;
        end
      end
      S_LAYER: begin
        if (stat.layer_hit) begin
          cmd.res_sel = RES_LAYER;
          state_next  = S_POST;
        end else if (stat.layer_end) begin
          cmd.res_sel = RES_DEFAULT;
          state_next  = S_POST;
        end else begin
          cmd.layer_step = 1'b1;
        end
      end
      S_POST: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ rtl/route_override_selector_unit.sv @@
// ----------------------------------------------------------------------------
// route_override_selector_unit
// Chooses the pipeline that receives motion from a table of key overrides,
// the active layer routes and a default pipeline.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_stall  | mode, key_position, target_route,
//           |                      | active_layers, base_layer
//  output   | out_valid / out_stall| status, route_valid, selected_route,
//           |                      | from_override
//  config   | cfg_we               | cfg_index, cfg_data
//
//  One transaction at a time. A press or release passes through accept, slot
//  search, update, newest-override scan and decision, then a layer scan from
//  the top layer down (skipped when an override is active) and hand-off; a
//  refresh skips the search and update. Reset clears the slot table, the order
//  stamp and the configuration to its defaults. A stall on the output holds
//  the result in the output register; the next transaction is taken meanwhile
//  and waits at its hand-off.
// ----------------------------------------------------------------------------
module route_override_selector_unit #(
  parameter int OVERRIDE_SLOTS = 8,
  parameter int NUM_LAYERS     = 16,
  parameter int ROUTE_MAX      = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  key_position,
  input  logic [2:0]  target_route,
  input  logic [15:0] active_layers,
  input  logic [3:0]  base_layer,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        route_valid,
  output logic [2:0]  selected_route,
  output logic        from_override
);
  import ros_pkg::*;

  ros_cmd_t  cmd;
  ros_stat_t stat;

  // Sequence each transaction: search, update, pick newest, scan layers
  ros_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the table, configuration and result registers
  ros_datapath #(
    .OVERRIDE_SLOTS (OVERRIDE_SLOTS),
    .NUM_LAYERS     (NUM_LAYERS),
    .ROUTE_MAX      (ROUTE_MAX)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mode           (mode),
    .key_position   (key_position),
    .target_route   (target_route),
    .active_layers  (active_layers),
    .base_layer     (base_layer),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .route_valid    (route_valid),
    .selected_route (selected_route),
    .from_override  (from_override)
  );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for route_override_selector_unit. Press, release and
// refresh transactions go in through the valid/stall input channel. A
// behavioral copy of the override table, the layer scan and the default
// pipeline predicts each result, and every result is compared field by
// field. A short table of directed transactions runs first, then random
// phases, each under its own register setting.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ros_pkg::*;

  localparam int SLOT_COUNT   = 8;
  localparam int LAYERS       = 16;
  localparam int ROUTE_LIMIT  = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 192;   // random transactions per phase
  localparam int KEY_POOL     = 10;    // more keys than slots, so the table can fill
  localparam int SETTLE       = 40;    // margin for the block to go idle after the last result
  localparam int QUIET_LIMIT  = 3000;  // cycles without any transaction
  localparam int IDLE_PCT     = 36;

  // Mode code with no function; the block must answer it and change nothing.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key;
    logic [2:0]  target;
    logic [15:0] layers;
    logic [3:0]  base;
  } route_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       valid;
    logic [2:0] route;
    logic       ovr;
  } route_pick_t;

  // One row of the directed table: either a register write or a transaction,
  // the latter with an optional typed-in expectation.
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [63:0] reg_val;
    route_req_t  req;
    bit          pinned;
    route_pick_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  key_position;
  logic [2:0]  target_route;
  logic [15:0] active_layers;
  logic [3:0]  base_layer;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        route_valid;
  logic [2:0]  selected_route;
  logic        from_override;

  // Predicted state of the block: override table, order stamp, registers.
  logic [7:0]  slot_key   [SLOT_COUNT];
  logic [2:0]  slot_pipe  [SLOT_COUNT];
  logic [63:0] slot_order [SLOT_COUNT];
  bit          slot_live  [SLOT_COUNT];
  logic [63:0] order_ctr;
  logic [2:0]  mdl_default;
  logic [3:0]  mdl_count;
  logic [63:0] mdl_map;

  route_pick_t picks_due [$];
  plan_row_t   plan [$];
  logic [7:0]  key_pool [KEY_POOL];

  bit          bursty;        // idling allowed on both sides
  bit          pinned_now;    // current transaction carries a typed-in result
  route_pick_t pinned_pick;
  int          mismatches;
  int          quiet;

  route_override_selector_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .key_position   (key_position),
    .target_route   (target_route),
    .active_layers  (active_layers),
    .base_layer     (base_layer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .route_valid    (route_valid),
    .selected_route (selected_route),
    .from_override  (from_override)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Scan from the top layer down; stop after the base layer. The first
  // active layer with a routed nibble wins, else fall back to the default.
  function automatic logic [2:0] layer_pipe(logic [15:0] layers, logic [3:0] base);
    for (int i = LAYERS - 1; i >= 0; i--) begin
      if (layers[i] && mdl_map[4*i+3]) return mdl_map[4*i +: 3];
      if (i == base) break;
    end
    return mdl_default;
  endfunction

  // Newest active override wins; on equal stamps the lowest slot stays.
  function automatic route_pick_t current_pick(logic [15:0] layers, logic [3:0] base);
    route_pick_t p;
    bit          found;
    logic [63:0] best;
    p = '0;
    found = 1'b0;
    best = '0;
    p.status = ST_OK;
    p.valid = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_live[i] && (!found || slot_order[i] > best)) begin
        found = 1'b1;
        best = slot_order[i];
        p.route = slot_pipe[i];
      end
    end
    p.ovr = found;
    if (!found) p.route = layer_pipe(layers, base);
    return p;
  endfunction

  // Apply one accepted transaction to the predicted table and return the
  // result the block must give for it.
  function automatic route_pick_t next_pick(route_req_t r);
    route_pick_t p;
    logic [3:0]  lim;
    bit          have;
    int          slot;
    p = '0;
    have = 1'b0;
    slot = 0;
    lim = (mdl_count < ROUTE_LIMIT) ? mdl_count : 4'(ROUTE_LIMIT);
    case (r.mode)
      MODE_REFRESH: p = current_pick(r.layers, r.base);
      MODE_PRESS: begin
        if ({1'b0, r.target} >= lim) begin
          p.status = ST_NOT_FOUND;
        end else begin
          // A matching live slot beats the first free one.
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_live[i] && slot_key[i] == r.key) begin
              have = 1'b1;
              slot = i;
              break;
            end
            if (!slot_live[i] && !have) begin
              have = 1'b1;
              slot = i;
            end
          end
          if (!have) begin
            p.status = ST_NO_SPACE;
          end else begin
            order_ctr = order_ctr + 64'd1;
            slot_key[slot] = r.key;
            slot_pipe[slot] = r.target;
            slot_order[slot] = order_ctr;
            slot_live[slot] = 1'b1;
            p = current_pick(r.layers, r.base);
          end
        end
      end
      MODE_RELEASE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_live[i] && slot_key[i] == r.key) begin
            slot_live[i] = 1'b0;
            p = current_pick(r.layers, r.base);
            break;
          end
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic flag(string what, logic [7:0] got, logic [7:0] want);
    $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Sample both channels at the rising edge. Predict on input acceptance,
  // compare on output acceptance, and bail out when nothing moves for long.
  always @(posedge clk) begin : watch
    route_pick_t got;
    route_pick_t want;
    bit          took;
    if (!rst) begin
      took = 1'b0;
      if (in_valid && !in_stall) begin
        want = next_pick({mode, key_position, target_route, active_layers, base_layer});
        picks_due.push_back(pinned_now ? pinned_pick : want);
        took = 1'b1;
      end
      if (out_valid && !out_stall) begin
        took = 1'b1;
        got = {status, route_valid, selected_route, from_override};
        if (picks_due.size() == 0) begin
          flag("unexpected result", 8'(got), 8'h00);
        end else begin
          want = picks_due.pop_front();
          if (got.status !== want.status) flag("status", 8'(got.status), 8'(want.status));
          if (got.valid !== want.valid) flag("route_valid", 8'(got.valid), 8'(want.valid));
          if (got.route !== want.route) flag("selected_route", 8'(got.route), 8'(want.route));
          if (got.ovr !== want.ovr) flag("from_override", 8'(got.ovr), 8'(want.ovr));
        end
      end
      quiet = took ? 0 : quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Receiver: stall at random while idling is allowed.
  always @(negedge clk) begin
    out_stall = bursty && ($urandom_range(99) < IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Offer one transaction and hold it until accepted. Enter and leave at a
  // falling edge; keep valid high when no gap is drawn.
  task automatic offer(route_req_t r, bit pinned, route_pick_t want);
    while (bursty && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode          = r.mode;
    key_position  = r.key;
    target_route  = r.target;
    active_layers = r.layers;
    base_layer    = r.base;
    pinned_now    = pinned;
    pinned_pick   = want;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result has come out, then give
  // the block time to go idle.
  task automatic settle();
    in_valid = 1'b0;
    while (picks_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DEFAULT_ROUTE:   mdl_default = val[2:0];
      REG_ROUTE_COUNT:     mdl_count = val[3:0];
      REG_LAYER_ROUTE_MAP: mdl_map = val;
      default: ;
    endcase
  endtask

  function automatic void add_reg(logic [1:0] idx, logic [63:0] val);
    plan_row_t row;
    row = '{is_reg: 1'b1, reg_idx: idx, reg_val: val, req: '0, pinned: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_req(logic [1:0] m, logic [7:0] k, logic [2:0] t,
                                  logic [15:0] l, logic [3:0] b);
    plan_row_t row;
    row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, req: {m, k, t, l, b},
            pinned: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  function automatic void add_pinned(logic [1:0] m, logic [7:0] k, logic [2:0] t,
                                     logic [15:0] l, logic [3:0] b, logic [1:0] st,
                                     logic v, logic [2:0] rt, logic ov);
    plan_row_t row;
    row = '{is_reg: 1'b0, reg_idx: '0, reg_val: '0, req: {m, k, t, l, b},
            pinned: 1'b1, want: {st, v, rt, ov}};
    plan.push_back(row);
  endfunction

  // Mostly presses and releases on a small key pool so the table fills,
  // empties and overflows; a few stray keys and a sprinkle of the unused mode.
  function automatic route_req_t rand_req();
    route_req_t r;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 42)      r.mode = MODE_PRESS;
    else if (roll < 72) r.mode = MODE_RELEASE;
    else if (roll < 97) r.mode = MODE_REFRESH;
    else                r.mode = MODE_UNUSED;
    r.key    = ($urandom_range(9) == 0) ? 8'($urandom) : key_pool[$urandom_range(KEY_POOL - 1)];
    r.target = 3'($urandom);
    r.layers = ($urandom_range(3) == 0) ? 16'(1) << $urandom_range(LAYERS - 1)
                                        : 16'($urandom);
    r.base   = 4'($urandom);
    return r;
  endfunction

  initial begin : main
    route_req_t  r;
    int          sent;
    logic [2:0]  def_v;
    logic [3:0]  cnt_v;
    logic [63:0] map_v;

    // Drive every input to a known value and hold reset.
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    mode          = '0;
    key_position  = '0;
    target_route  = '0;
    active_layers = '0;
    base_layer    = '0;
    out_stall     = 1'b0;
    bursty        = 1'b1;
    pinned_now    = 1'b0;
    pinned_pick   = '0;
    mismatches    = 0;
    quiet         = 0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_key[i]   = '0;
      slot_pipe[i]  = '0;
      slot_order[i] = '0;
      slot_live[i]  = 1'b0;
    end
    order_ctr   = '0;
    mdl_default = 3'd0;
    mdl_count   = 4'd1;
    mdl_map     = '0;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed table. Registers start at their reset values: default 0,
    // one pipeline, no layer routes.
    add_pinned(MODE_REFRESH, 8'h00, 3'd0, 16'hFFFF, 4'd0, ST_OK, 1'b1, 3'd0, 1'b0);
    add_pinned(MODE_PRESS,   8'h00, 3'd7, 16'h0000, 4'd0, ST_NOT_FOUND, 1'b0, 3'd0, 1'b0);
    add_pinned(MODE_PRESS,   8'h00, 3'd0, 16'h0000, 4'd0, ST_OK, 1'b1, 3'd0, 1'b1);
    // Release of an unknown key and the unused mode change nothing.
    add_pinned(MODE_RELEASE, 8'hFF, 3'd0, 16'h0000, 4'd0, ST_OK, 1'b0, 3'd0, 1'b0);
    add_pinned(MODE_UNUSED,  8'h00, 3'd7, 16'hFFFF, 4'd15, ST_OK, 1'b0, 3'd0, 1'b0);
    add_pinned(MODE_RELEASE, 8'h00, 3'd0, 16'h0000, 4'd0, ST_OK, 1'b1, 3'd0, 1'b0);
    // Full pipeline range, default 7, routes on the top and bottom layers.
    add_reg(REG_ROUTE_COUNT, 64'd8);
    add_reg(REG_DEFAULT_ROUTE, 64'd7);
    add_reg(REG_LAYER_ROUTE_MAP, 64'hF000_0000_0000_0008);
    add_pinned(MODE_REFRESH, 8'h00, 3'd0, 16'h0000, 4'd0, ST_OK, 1'b1, 3'd7, 1'b0);
    add_pinned(MODE_REFRESH, 8'h00, 3'd0, 16'h8001, 4'd0, ST_OK, 1'b1, 3'd7, 1'b0);
    add_pinned(MODE_REFRESH, 8'h00, 3'd0, 16'h0001, 4'd0, ST_OK, 1'b1, 3'd0, 1'b0);
    // Base layer at the top: the scan stops before reaching layer 0.
    add_pinned(MODE_REFRESH, 8'h00, 3'd0, 16'h0001, 4'd15, ST_OK, 1'b1, 3'd7, 1'b0);
    add_req(MODE_REFRESH, 8'h00, 3'd0, 16'h7FFE, 4'd4);
    add_pinned(MODE_PRESS, 8'hFF, 3'd7, 16'h0000, 4'd0, ST_OK, 1'b1, 3'd7, 1'b1);
    add_req(MODE_PRESS, 8'h00, 3'd3, 16'h8001, 4'd0);
    // Re-press of a held key restamps its slot.
    add_req(MODE_PRESS, 8'hFF, 3'd5, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h01, 3'd1, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h02, 3'd2, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h04, 3'd4, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h08, 3'd6, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h10, 3'd0, 16'h0000, 4'd0);
    add_req(MODE_PRESS, 8'h20, 3'd7, 16'h0000, 4'd0);
    // Table full: a new key gets no slot.
    add_pinned(MODE_PRESS, 8'h40, 3'd1, 16'h0000, 4'd0, ST_NO_SPACE, 1'b0, 3'd0, 1'b0);
    add_req(MODE_RELEASE, 8'h00, 3'd0, 16'hFFFF, 4'd0);
    add_req(MODE_PRESS,   8'h80, 3'd2, 16'h0000, 4'd0);
    add_req(MODE_RELEASE, 8'h80, 3'd0, 16'h8001, 4'd3);

    foreach (plan[k]) begin
      if (plan[k].is_reg) begin
        settle();
        write_reg(plan[k].reg_idx, plan[k].reg_val);
      end else begin
        offer(plan[k].req, plan[k].pinned, plan[k].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      def_v = 3'($urandom_range(7));
      cnt_v = 4'($urandom_range(1, 8));
      map_v = {$urandom, $urandom};
      case (ph)
        0: begin
          def_v = 3'd3;
          cnt_v = 4'd8;
        end
        1: begin
          // No pipeline present: every press is refused.
          def_v = 3'd0;
          cnt_v = 4'd0;
          map_v = '0;
        end
        2: begin
          def_v = 3'd7;
          cnt_v = 4'd15;
          map_v = '1;
        end
        3: cnt_v = 4'd1;
        5: cnt_v = 4'd8;
        6: cnt_v = 4'd4;
        7: cnt_v = 4'($urandom_range(15));
        default: ;
      endcase
      write_reg(REG_DEFAULT_ROUTE, 64'(def_v));
      write_reg(REG_ROUTE_COUNT, 64'(cnt_v));
      write_reg(REG_LAYER_ROUTE_MAP, map_v);
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = 8'($urandom);
      // Run one phase back to back with no idling on either side.
      bursty = (ph != 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = rand_req();
        offer(r, 1'b0, '0);
        if (r.mode != MODE_UNUSED) begin
          sent++;
          // Hold the sender once until every result has drained.
          if (ph == 5 && sent == PHASE_ITEMS / 2) settle();
        end
      end
    end

    settle();
    if (picks_due.size() != 0) flag("results missing", 8'(picks_due.size()), 8'h00);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
